// ----- hdl/isotp_rr_pkg.sv -----
// Shared types and constants for the ISO-TP receive reassembler.
// Used by the front end, the job queue, the result sequencer and the top level.
package isotp_rr_pkg;

  localparam logic [11:0] MaxMessageLength = 12'd4095;

  // Input action codes
  localparam logic [1:0] ActArm   = 2'd0;
  localparam logic [1:0] ActFrame = 2'd1;
  localparam logic [1:0] ActTick  = 2'd2;

  // Result kinds
  localparam logic [1:0] KindByte    = 2'd0;
  localparam logic [1:0] KindFlow    = 2'd1;
  localparam logic [1:0] KindDone    = 2'd2;
  localparam logic [1:0] KindTimeout = 2'd3;

  // Receive phases
  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhFirst  = 2'd1;
  localparam logic [1:0] PhConsec = 2'd2;

  // Protocol control byte frame types
  localparam logic [3:0] PciSingle = 4'h0;
  localparam logic [3:0] PciFirst  = 4'h1;
  localparam logic [3:0] PciConsec = 4'h2;

  localparam logic [2:0] SfMaxBytes = 3'd7;
  localparam logic [2:0] FfBytes    = 3'd6;
  localparam logic [2:0] CfMaxBytes = 3'd7;

  // Register indexes
  localparam logic [1:0] RegResponseId = 2'd0;
  localparam logic [1:0] RegRequestId  = 2'd1;
  localparam logic [1:0] RegMaxLength  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [28:0] can_id;
    logic [3:0]  frame_len;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;
    logic [15:0] timeout_ms;
  } in_item_t;

  typedef struct packed {
    logic [28:0] response_id;
    logic [11:0] max_length;
  } front_cfg_t;

  // One classified frame: payload bytes to deliver, then an optional tail result
  typedef struct packed {
    logic [6:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic [11:0]     base_idx;
    logic            has_tail;
    logic [1:0]      tail_kind;
    logic [11:0]     tail_len;
  } job_t;

endpackage

// ----- hdl/isotp_rr_front.sv -----
// Front end: accepts input items, tracks the reception state, builds jobs.
// Depends on isotp_rr_pkg.
module isotp_rr_front import isotp_rr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  front_cfg_t cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   item_i,
  input  logic       q_full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [1:0]  phase_q, phase_d;
  logic [15:0] time_left_q, time_left_d;
  logic [11:0] target_q, target_d;
  logic [11:0] rcount_q, rcount_d;
  logic [3:0]  eseq_q, eseq_d;

  logic [11:0] eff_max;
  logic [3:0]  typ, nib;
  logic        frame_ok;
  logic [2:0]  sf_n3;
  logic [11:0] ff_len, ff_n, remain, rc_new;
  logic [2:0]  cf_n;
  logic [15:0] tl_new;
  logic        accept, emit;
  job_t        job;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    eff_max  = (cfg_i.max_length > MaxMessageLength) ? MaxMessageLength : cfg_i.max_length;
    typ      = item_i.byte0[7:4];
    nib      = item_i.byte0[3:0];
    frame_ok = (phase_q != PhIdle) && (item_i.can_id == cfg_i.response_id)
               && (item_i.frame_len != 4'd0);
    sf_n3    = (nib > {1'b0, SfMaxBytes}) ? SfMaxBytes : nib[2:0];
    if ({9'd0, sf_n3} > eff_max) sf_n3 = eff_max[2:0];
    ff_len   = {nib, item_i.byte1};
    ff_n     = (ff_len > eff_max) ? eff_max : ff_len;
    remain   = (target_q > rcount_q) ? (target_q - rcount_q) : 12'd0;
    cf_n     = (remain > {9'd0, CfMaxBytes}) ? CfMaxBytes : remain[2:0];
    rc_new   = rcount_q + {9'd0, cf_n};
    tl_new   = (time_left_q != 16'd0) ? (time_left_q - 16'd1) : 16'd0;

    phase_d     = phase_q;
    time_left_d = time_left_q;
    target_d    = target_q;
    rcount_d    = rcount_q;
    eseq_d      = eseq_q;
    job         = '0;

    unique case (item_i.action)
      ActArm: begin
        rcount_d    = 12'd0;
        target_d    = 12'd0;
        eseq_d      = 4'd1;
        time_left_d = item_i.timeout_ms;
        phase_d     = PhFirst;
        if (eff_max == 12'd0) begin
          phase_d       = PhIdle;
          job.has_tail  = 1'b1;
          job.tail_kind = KindDone;
        end else if (item_i.timeout_ms == 16'd0) begin
          phase_d       = PhIdle;
          job.has_tail  = 1'b1;
          job.tail_kind = KindTimeout;
        end
      end
      ActTick: begin
        if (phase_q != PhIdle) begin
          time_left_d = tl_new;
          if (tl_new == 16'd0) begin
            phase_d       = PhIdle;
            job.has_tail  = 1'b1;
            job.tail_kind = KindTimeout;
            job.tail_len  = rcount_q;
          end
        end
      end
      ActFrame: begin
        if (frame_ok && phase_q == PhFirst && typ == PciSingle) begin
          job.bytes     = {item_i.byte7, item_i.byte6, item_i.byte5, item_i.byte4,
                           item_i.byte3, item_i.byte2, item_i.byte1};
          job.nbytes    = sf_n3;
          job.has_tail  = 1'b1;
          job.tail_kind = KindDone;
          job.tail_len  = {9'd0, sf_n3};
          rcount_d      = {9'd0, sf_n3};
          phase_d       = PhIdle;
        end else if (frame_ok && phase_q == PhFirst && typ == PciFirst
                     && item_i.frame_len >= 4'd2) begin
          job.bytes = {8'd0, item_i.byte7, item_i.byte6, item_i.byte5,
                       item_i.byte4, item_i.byte3, item_i.byte2};
          if (ff_n <= {9'd0, FfBytes}) begin
            job.nbytes    = ff_n[2:0];
            job.has_tail  = 1'b1;
            job.tail_kind = KindDone;
            job.tail_len  = ff_n;
            rcount_d      = ff_n;
            phase_d       = PhIdle;
          end else begin
            job.nbytes    = FfBytes;
            job.has_tail  = 1'b1;
            job.tail_kind = KindFlow;
            target_d      = ff_n;
            rcount_d      = {9'd0, FfBytes};
            eseq_d        = 4'd1;
            phase_d       = PhConsec;
          end
        end else if (frame_ok && phase_q == PhConsec && typ == PciConsec
                     && nib == eseq_q) begin
          eseq_d       = eseq_q + 4'd1;
          job.bytes    = {item_i.byte7, item_i.byte6, item_i.byte5, item_i.byte4,
                          item_i.byte3, item_i.byte2, item_i.byte1};
          job.nbytes   = cf_n;
          job.base_idx = rcount_q;
          rcount_d     = rc_new;
          if (rc_new >= target_q) begin
            phase_d       = PhIdle;
            job.has_tail  = 1'b1;
            job.tail_kind = KindDone;
            job.tail_len  = rc_new;
          end
        end
      end
      default: begin
        // unused action code: drop the item
      end
    endcase
    emit = (job.nbytes != 3'd0) || job.has_tail;
  end

  assign push_o = accept && emit;
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      time_left_q <= 16'd0;
      target_q    <= 12'd0;
      rcount_q    <= 12'd0;
      eseq_q      <= 4'd1;
    end else if (accept) begin
      phase_q     <= phase_d;
      time_left_q <= time_left_d;
      target_q    <= target_d;
      rcount_q    <= rcount_d;
      eseq_q      <= eseq_d;
    end
  end

endmodule

// ----- hdl/isotp_rr_fifo.sv -----
// Two-entry job queue between the front end and the result sequencer.
// Depends on isotp_rr_pkg.
module isotp_rr_fifo import isotp_rr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign job_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i) rptr_q <= !rptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ----- hdl/isotp_rr_back.sv -----
// Result sequencer: expands jobs into results in an output register, one per ready cycle.
// Depends on isotp_rr_pkg.
module isotp_rr_back import isotp_rr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [28:0] request_id_i,
  input  logic        head_valid_i,
  input  job_t        head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [28:0] frame_id_o,
  output logic [7:0]  byte_value_o,
  output logic [11:0] byte_index_o,
  output logic [11:0] message_length_o,
  output logic        last_o
);

  logic [2:0]  cnt_q;
  logic        valid_q;
  logic [1:0]  kind_q;
  logic [28:0] frame_id_q;
  logic [7:0]  byte_value_q;
  logic [11:0] byte_index_q, message_length_q;
  logic        last_q;

  logic [3:0]  total;
  logic        is_byte, is_final, load;
  logic [2:0]  sel;

  always_comb begin
    total    = {1'b0, head_i.nbytes} + {3'd0, head_i.has_tail};
    is_byte  = cnt_q < head_i.nbytes;
    is_final = ({1'b0, cnt_q} == (total - 4'd1));
    sel      = is_byte ? cnt_q : 3'd0;
    load     = head_valid_i && (!valid_q || out_ready_i);
  end

  assign pop_o = load && is_final;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= 3'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        cnt_q   <= is_final ? 3'd0 : (cnt_q + 3'd1);
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      last_q <= is_final;
      if (is_byte) begin
        kind_q           <= KindByte;
        frame_id_q       <= 29'd0;
        byte_value_q     <= head_i.bytes[sel];
        byte_index_q     <= head_i.base_idx + {9'd0, cnt_q};
        message_length_q <= 12'd0;
      end else begin
        kind_q           <= head_i.tail_kind;
        frame_id_q       <= (head_i.tail_kind == KindFlow) ? request_id_i : 29'd0;
        byte_value_q     <= 8'd0;
        byte_index_q     <= 12'd0;
        message_length_q <= (head_i.tail_kind == KindFlow) ? 12'd0 : head_i.tail_len;
      end
    end
  end

  assign out_valid_o      = valid_q;
  assign kind_o           = kind_q;
  assign frame_id_o       = frame_id_q;
  assign byte_value_o     = byte_value_q;
  assign byte_index_o     = byte_index_q;
  assign message_length_o = message_length_q;
  assign last_o           = last_q;

endmodule

// ----- hdl/isotp_receive_reassembler_unit.sv -----
// Top level of the ISO-TP receive reassembler: register port, front end, queue, sequencer.
// Depends on isotp_rr_pkg, isotp_rr_front, isotp_rr_fifo and isotp_rr_back.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+---------------------------------------------
//   input    | in_valid_i / in_ready_o      | action, can_id, frame_len, byte0..7, timeout_ms
//   result   | out_valid_o / out_ready_i    | kind, frame_id, byte_value, byte_index,
//            |                              | message_length, last
//   config   | psel, penable, pwrite/pready | paddr, pwdata, prdata (APB, 32 bit)
//
// An item is classified and its state update applied in the cycle it is accepted;
// its results (up to eight) then leave the output register one per cycle while
// out_ready_i is high. A two-entry job queue parts the two sides: items keep coming
// while earlier results drain, and in_ready_o drops only when the queue is full.
// Reset (rst_ni low, asynchronous) restores idle phase and register defaults.
// Items that cause no result never enter the queue.
module isotp_receive_reassembler_unit import isotp_rr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [28:0] can_id_i,
  input  logic [3:0]  frame_len_i,
  input  logic [7:0]  byte0_i,
  input  logic [7:0]  byte1_i,
  input  logic [7:0]  byte2_i,
  input  logic [7:0]  byte3_i,
  input  logic [7:0]  byte4_i,
  input  logic [7:0]  byte5_i,
  input  logic [7:0]  byte6_i,
  input  logic [7:0]  byte7_i,
  input  logic [15:0] timeout_ms_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [28:0] frame_id_o,
  output logic [7:0]  byte_value_o,
  output logic [11:0] byte_index_o,
  output logic [11:0] message_length_o,
  output logic        last_o
);

  logic [28:0] response_id_q;
  logic [28:0] request_id_q;
  logic [11:0] max_length_q;
  logic        cfg_wr;

  front_cfg_t  front_cfg;
  in_item_t    item;
  job_t        push_job, head_job;
  logic        push, q_full, head_valid, pop;

  // Register file: always ready, written at the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      response_id_q <= 29'd2024;
      request_id_q  <= 29'd2016;
      max_length_q  <= 12'd64;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegResponseId: response_id_q <= pwdata[28:0];
        RegRequestId:  request_id_q  <= pwdata[28:0];
        RegMaxLength:  max_length_q  <= pwdata[11:0];
        default: begin
          // address beyond the register list: drop the write
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegResponseId: prdata = {3'd0, response_id_q};
      RegRequestId:  prdata = {3'd0, request_id_q};
      RegMaxLength:  prdata = {20'd0, max_length_q};
      default:       prdata = 32'd0;
    endcase
  end

  assign front_cfg.response_id = response_id_q;
  assign front_cfg.max_length  = max_length_q;

  assign item.action     = action_i;
  assign item.can_id     = can_id_i;
  assign item.frame_len  = frame_len_i;
  assign item.byte0      = byte0_i;
  assign item.byte1      = byte1_i;
  assign item.byte2      = byte2_i;
  assign item.byte3      = byte3_i;
  assign item.byte4      = byte4_i;
  assign item.byte5      = byte5_i;
  assign item.byte6      = byte6_i;
  assign item.byte7      = byte7_i;
  assign item.timeout_ms = timeout_ms_i;

  // Classify the item and advance the reception state
  isotp_rr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (front_cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // Hold pending jobs while the result side stalls
  isotp_rr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  // Expand each job into its results, one transfer per cycle while out_ready_i is high
  isotp_rr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .request_id_i     (request_id_q),
    .head_valid_i     (head_valid),
    .head_i           (head_job),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .frame_id_o       (frame_id_o),
    .byte_value_o     (byte_value_o),
    .byte_index_o     (byte_index_o),
    .message_length_o (message_length_o),
    .last_o           (last_o)
  );

  // Completion and timeout results always close their item
  a_tail_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KindDone || kind_o == KindTimeout) |-> last_o)
    else $error("done or timeout result not marked last");

  // A flow control result carries the request id and no length or data
  a_flow_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindFlow |->
      frame_id_o == request_id_q && message_length_o == 12'd0 && byte_value_o == 8'd0)
    else $error("flow control result carries wrong fields");

  // Payload bytes never carry an id or a length
  a_byte_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindByte |-> frame_id_o == 29'd0 && message_length_o == 12'd0)
    else $error("payload byte result carries id or length");

  // The queue is never pushed while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job queue overflow");

endmodule

// ----- test/tb_isotp_receive_reassembler_unit.sv -----
// Testbench for the ISO-TP receive reassembler: a self-checking scoreboard plus stimulus.
// Depends on isotp_rr_pkg and isotp_receive_reassembler_unit; needs nothing else.
// Directed protocol corner cases first, then random messages over several register settings.
`timescale 1ns / 1ps

import isotp_rr_pkg::*;

typedef struct packed {
  logic [1:0]  kind;
  logic [28:0] frame_id;
  logic [7:0]  byte_value;
  logic [11:0] byte_index;
  logic [11:0] message_length;
  logic        last;
} rx_result_t;

// Tracks receive state and register values, and holds the results still owed by the block.
class reassembly_scoreboard;
  logic [28:0] resp_id    = 29'd2024;
  logic [28:0] req_id     = 29'd2016;
  logic [11:0] max_len    = 12'd64;
  logic [1:0]  phase      = PhIdle;
  logic [15:0] time_left  = '0;
  logic [11:0] target_len = '0;
  logic [11:0] rx_count   = '0;
  logic [3:0]  next_seq   = 4'd1;
  rx_result_t  awaited[$];
  int unsigned mismatches = 0;

  function void write_reg(logic [1:0] idx, logic [31:0] value);
    case (idx)
      RegResponseId: resp_id = value[28:0];
      RegRequestId:  req_id = value[28:0];
      RegMaxLength:  max_len = value[11:0];
      default: ;
    endcase
  endfunction

  function void push(logic [1:0] kind, logic [28:0] fid, logic [7:0] val, logic [11:0] idx,
                     logic [11:0] mlen);
    rx_result_t r;
    r = {kind, fid, val, idx, mlen, 1'b0};
    awaited.push_back(r);
  endfunction

  // Apply one accepted transfer; returns 1 unless the block just drops it.
  function bit predict_item(in_item_t it);
    logic [7:0]  data [0:7];
    int unsigned lim, n, start, i;
    bit          acted;
    rx_result_t  tail;
    data = '{it.byte0, it.byte1, it.byte2, it.byte3, it.byte4, it.byte5, it.byte6, it.byte7};
    start = awaited.size();
    acted = 1'b0;
    lim = (max_len > MaxMessageLength) ? MaxMessageLength : max_len;
    case (it.action)
      ActArm: begin
        acted = 1'b1;
        rx_count = '0;
        target_len = '0;
        next_seq = 4'd1;
        time_left = it.timeout_ms;
        phase = PhFirst;
        if (lim == 0) begin
          phase = PhIdle;
          push(KindDone, '0, '0, '0, '0);
        end else if (it.timeout_ms == '0) begin
          phase = PhIdle;
          push(KindTimeout, '0, '0, '0, '0);
        end
      end
      ActTick: begin
        if (phase != PhIdle) begin
          acted = 1'b1;
          if (time_left != '0) time_left--;
          if (time_left == '0) begin
            phase = PhIdle;
            push(KindTimeout, '0, '0, '0, rx_count);
          end
        end
      end
      ActFrame: begin
        if (phase != PhIdle && it.can_id == resp_id && it.frame_len != '0) begin
          if (phase == PhFirst && it.byte0[7:4] == PciSingle) begin
            acted = 1'b1;
            n = it.byte0[3:0];
            if (n > SfMaxBytes) n = SfMaxBytes;
            if (n > lim) n = lim;
            for (i = 0; i < n; i++) push(KindByte, '0, data[1 + i], 12'(i), '0);
            rx_count = 12'(n);
            phase = PhIdle;
            push(KindDone, '0, '0, '0, 12'(n));
          end else if (phase == PhFirst && it.byte0[7:4] == PciFirst && it.frame_len >= 2) begin
            acted = 1'b1;
            n = {it.byte0[3:0], it.byte1};
            if (n > lim) n = lim;
            if (n <= FfBytes) begin
              for (i = 0; i < n; i++) push(KindByte, '0, data[2 + i], 12'(i), '0);
              rx_count = 12'(n);
              phase = PhIdle;
              push(KindDone, '0, '0, '0, 12'(n));
            end else begin
              for (i = 0; i < FfBytes; i++) push(KindByte, '0, data[2 + i], 12'(i), '0);
              push(KindFlow, req_id, '0, '0, '0);
              target_len = 12'(n);
              rx_count = 12'(FfBytes);
              next_seq = 4'd1;
              phase = PhConsec;
            end
          end else if (phase == PhConsec && it.byte0[7:4] == PciConsec &&
                       it.byte0[3:0] == next_seq) begin
            acted = 1'b1;
            next_seq++;
            n = (target_len > rx_count) ? target_len - rx_count : 0;
            if (n > CfMaxBytes) n = CfMaxBytes;
            for (i = 0; i < n; i++) push(KindByte, '0, data[1 + i], 12'(rx_count + i), '0);
            rx_count = 12'(rx_count + n);
            if (rx_count >= target_len) begin
              phase = PhIdle;
              push(KindDone, '0, '0, '0, rx_count);
            end
          end
        end
      end
      default: ;
    endcase
    // flag the final result of this transfer
    if (awaited.size() > start) begin
      tail = awaited.pop_back();
      tail.last = 1'b1;
      awaited.push_back(tail);
    end
    return acted;
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  function void check_result(rx_result_t got);
    rx_result_t want;
    if (awaited.size() == 0) begin
      mismatches++;
      $display("%0t: result with none expected, expected nothing, actual kind %0d index %0d",
               $time, got.kind, got.byte_index);
    end else begin
      want = awaited.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("frame_id", 32'(want.frame_id), 32'(got.frame_id));
      compare_field("byte_value", 32'(want.byte_value), 32'(got.byte_value));
      compare_field("byte_index", 32'(want.byte_index), 32'(got.byte_index));
      compare_field("message_length", 32'(want.message_length), 32'(got.message_length));
      compare_field("last", 32'(want.last), 32'(got.last));
    end
  endfunction
endclass

module tb_isotp_receive_reassembler_unit;

  localparam logic [1:0]  ActUnused    = 2'd3;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned HoldCycles   = 150;
  localparam int unsigned MaxConsec    = 20;

  typedef enum logic [1:0] {StallNone, StallRandom, StallPattern} stall_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  action_i;
  logic [28:0] can_id_i;
  logic [3:0]  frame_len_i;
  logic [7:0]  byte0_i, byte1_i, byte2_i, byte3_i, byte4_i, byte5_i, byte6_i, byte7_i;
  logic [15:0] timeout_ms_i;
  logic        out_valid_o, out_ready_i;
  logic [1:0]  kind_o;
  logic [28:0] frame_id_o;
  logic [7:0]  byte_value_o;
  logic [11:0] byte_index_o, message_length_o;
  logic        last_o;

  in_item_t             offered;        // payload currently on the input channel
  reassembly_scoreboard sb;
  int unsigned          taken_items;    // transfers the block actually acted on
  int unsigned          burst_left;
  bit                   hold_pending;   // asks the receiver for one long hold-off

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  assign {action_i, can_id_i, frame_len_i, byte0_i, byte1_i, byte2_i, byte3_i,
          byte4_i, byte5_i, byte6_i, byte7_i, timeout_ms_i} = offered;

  isotp_receive_reassembler_unit DUT (.*);

  // Sample both channels in one place so a transfer is always predicted before any result
  // that could follow it is checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o && sb.predict_item(offered)) taken_items++;
      if (out_valid_o && out_ready_i)
        sb.check_result({kind_o, frame_id_o, byte_value_o, byte_index_o, message_length_o,
                         last_o});
    end
  end

  // Result side: switch between stall styles at random intervals; on request,
  // hold off for a long stretch so the job queue fills and the input stalls.
  initial begin
    stall_mode_e mode;
    int unsigned mode_left;
    logic [7:0]  mask;
    logic [2:0]  rot;
    out_ready_i = 1'b0;
    mode_left = 0;
    rot = '0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready_i = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 80);
          mask = 8'($urandom_range(1, 255));
        end
        mode_left--;
        rot++;
        case (mode)
          StallNone:   out_ready_i = 1'b1;
          StallRandom: out_ready_i = ($urandom_range(0, 3) != 0);
          default:     out_ready_i = mask[rot];
        endcase
      end
    end
  end

  // Generous ceiling: several times the slowest legal run.
  initial begin
    #3_200_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic in_item_t random_item();
    in_item_t it;
    it.action = 2'($urandom_range(0, 3));
    it.can_id = 29'($urandom());
    it.frame_len = 4'($urandom_range(0, 15));
    {it.byte0, it.byte1, it.byte2, it.byte3} = $urandom();
    {it.byte4, it.byte5, it.byte6, it.byte7} = $urandom();
    it.timeout_ms = 16'($urandom());
    return it;
  endfunction

  function automatic in_item_t arm_item(logic [15:0] tmo);
    in_item_t it;
    it = random_item();
    it.action = ActArm;
    it.timeout_ms = tmo;
    return it;
  endfunction

  function automatic in_item_t tick_item();
    in_item_t it;
    it = random_item();
    it.action = ActTick;
    return it;
  endfunction

  // Bytes past byte1 stay random: the block must use them as given.
  function automatic in_item_t frame_item(logic [28:0] cid, logic [3:0] flen, logic [7:0] pci,
                                          logic [7:0] b1);
    in_item_t it;
    it = random_item();
    it.action = ActFrame;
    it.can_id = cid;
    it.frame_len = flen;
    it.byte0 = pci;
    it.byte1 = b1;
    return it;
  endfunction

  // Something the reassembler must reject or that disturbs the current message.
  function automatic in_item_t noise_item(logic [28:0] rid, logic [3:0] seq);
    in_item_t it;
    case ($urandom_range(0, 5))
      0: it = frame_item(rid ^ (29'd1 << $urandom_range(0, 28)), 4'd8, 8'($urandom()),
                         8'($urandom()));
      1: it = frame_item(rid, 4'd0, 8'($urandom()), 8'($urandom()));
      2: it = frame_item(rid, 4'($urandom_range(1, 8)),
                         {PciConsec, seq + 4'($urandom_range(1, 15))}, 8'($urandom()));
      3: it = frame_item(rid, 4'($urandom_range(1, 8)),
                         {4'($urandom_range(3, 15)), 4'($urandom())}, 8'($urandom()));
      4: it = tick_item();
      default: it = random_item();
    endcase
    return it;
  endfunction

  // Offer one transfer and hold it until accepted; gaps come between random-length bursts.
  task automatic offer(in_item_t it);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    offered = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop sending until every owed result is out, then let the front end go quiet.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic directed_checks();
    logic [28:0] rid;
    rid = sb.resp_id;
    offer(tick_item());                                  // tick while idle: dropped
    offer(frame_item(rid, 4'd8, 8'h03, 8'h11));         // frame while idle: dropped
    offer(arm_item(16'h0000));                          // zero timeout: times out at once
    offer(arm_item(16'hFFFF));
    offer(frame_item(rid ^ 29'h1, 4'd8, 8'h03, 8'h22)); // foreign id
    offer(frame_item(rid, 4'd0, 8'h03, 8'h22));         // empty frame
    offer(frame_item(rid, 4'd8, 8'h35, 8'h22));         // unknown frame type
    offer(frame_item(rid, 4'd1, 8'h10, 8'h20));         // first frame too short
    offer(frame_item(rid, 4'd8, 8'h0F, 8'hFF));         // single frame, length clamped to 7
    offer(arm_item(16'hFFFF));
    offer(frame_item(rid, 4'd1, 8'h00, 8'h00));         // single frame of zero bytes
    offer(arm_item(16'd100));
    offer(frame_item(rid, 4'd2, 8'h10, 8'h05));         // first frame that fits on its own
    offer(arm_item(16'd3));
    offer(frame_item(rid, 4'd8, 8'h1F, 8'hFF));         // 4095 clamped to the maximum
    offer(frame_item(rid, 4'd8, 8'h22, 8'h33));         // out-of-order sequence number
    offer(frame_item(rid, 4'd8, 8'h05, 8'h33));         // single frame mid-message
    offer(frame_item(rid, 4'd8, 8'h21, 8'h44));
    repeat (3) offer(tick_item());                      // expire with a partial count
    offer(arm_item(16'd10));
    offer(frame_item(rid, 4'd8, 8'h10, 8'd20));
    offer(arm_item(16'd5));                             // re-arm abandons the message
    begin
      in_item_t odd;
      odd = random_item();
      odd.action = ActUnused;
      offer(odd);
    end
    offer(frame_item(rid, 4'd4, 8'h03, 8'h55));
  endtask

  // One arm plus a mostly well-formed message with random content and some disturbance.
  task automatic run_message();
    logic [15:0] tmo;
    logic [11:0] length;
    logic [3:0]  seq;
    int unsigned lim, target, cfs, k;
    lim = sb.max_len;
    case ($urandom_range(0, 9))
      0:       tmo = 16'($urandom_range(1, 6));   // short: ticks below expire it
      1:       tmo = 16'($urandom());
      default: tmo = 16'($urandom_range(200, 65535));
    endcase
    offer(arm_item(tmo));
    if ($urandom_range(0, 4) < 2) begin
      offer(frame_item(sb.resp_id, 4'($urandom_range(1, 8)), {PciSingle, 4'($urandom())},
                       8'($urandom())));
    end else begin
      case ($urandom_range(0, 9))
        0:       length = 12'($urandom());
        1, 2:    length = 12'($urandom_range(0, 150));
        default: length = 12'($urandom_range(7, 40));
      endcase
      offer(frame_item(sb.resp_id, 4'($urandom_range(2, 8)), {PciFirst, length[11:8]},
                       length[7:0]));
      target = (length > lim) ? lim : length;
      cfs = (target > FfBytes) ? (target - FfBytes + CfMaxBytes - 1) / CfMaxBytes : 0;
      if (cfs > MaxConsec) cfs = MaxConsec;
      seq = 4'd1;
      for (k = 0; k < cfs; k++) begin
        if ($urandom_range(0, 5) == 0) offer(noise_item(sb.resp_id, seq));
        offer(frame_item(sb.resp_id, 4'($urandom_range(1, 8)), {PciConsec, seq},
                         8'($urandom())));
        seq++;
      end
    end
    if (tmo <= 16'd6) begin
      repeat (int'(tmo) + 1) offer(tick_item());
    end else if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) offer(tick_item());
    end
    if ($urandom_range(0, 19) == 0) drain();
  endtask

  // Reprogram all registers while idle, then run random messages under that setting.
  task automatic run_phase(logic [28:0] rid, logic [28:0] qid, logic [11:0] ml,
                           int unsigned quota, bit with_hold);
    int unsigned stop;
    drain();
    apb_write(RegResponseId, {3'b000, rid});
    apb_write(RegRequestId, {3'b000, qid});
    apb_write(RegMaxLength, {20'd0, ml});
    if (with_hold) hold_pending = 1'b1;
    stop = taken_items + quota;
    while (taken_items < stop) run_message();
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    offered = '0;
    taken_items = 0;
    burst_left = 0;
    hold_pending = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed_checks();

    // extremes first, then narrow, mid and arbitrary limits
    run_phase(29'd0, 29'h1FFF_FFFF, 12'd4095, 26, 1'b0);
    run_phase(29'h1FFF_FFFF, 29'd0, 12'd0, 4, 1'b0);
    run_phase(29'($urandom()), 29'($urandom()), 12'd1, 10, 1'b0);
    run_phase(29'($urandom()), 29'($urandom()), 12'd7, 14, 1'b0);
    run_phase(29'($urandom()), 29'($urandom()), 12'd200, 26, 1'b1);
    run_phase(29'($urandom()), 29'($urandom()), 12'($urandom()), 26, 1'b0);
    drain();

    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
